// ===== hw/rtl/ita_pkg.sv =====
`timescale 1ns / 1ps

package ita_pkg;

    localparam int unsigned ValueWidth = 32;
    localparam int unsigned CharWidth  = 7;
    localparam int unsigned DigitWidth = 4;
    localparam int unsigned NumDigits  = 10;
    localparam int unsigned DigitsWidth = NumDigits * DigitWidth;
    localparam int unsigned BitCountWidth = $clog2(ValueWidth);
    localparam int unsigned LeftWidth = $clog2(NumDigits + 1);

    localparam logic [CharWidth-1:0] CharZero  = 7'h30;
    localparam logic [CharWidth-1:0] CharA     = 7'h61;
    localparam logic [CharWidth-1:0] CharMinus = 7'h2d;
    localparam logic [DigitWidth-1:0] DigitTen = 4'd10;

    typedef struct packed {
        logic [DigitsWidth-1:0] digits;
        logic                   neg;
    } ita_word_t;

    typedef enum logic [1:0] {
        CONV_IDLE,
        CONV_SHIFT,
        CONV_DONE
    } conv_state_t;

    typedef enum logic [1:0] {
        EMIT_IDLE,
        EMIT_SIGN,
        EMIT_SKIP,
        EMIT_DIGIT
    } emit_state_t;

    function automatic logic [CharWidth-1:0] digit_char(input logic [DigitWidth-1:0] d);
        logic [CharWidth-1:0] c;
        if (d < DigitTen)
        begin
            c = CharZero + CharWidth'(d);
        end
        else
        begin
            c = CharA + CharWidth'(d - DigitTen);
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/integer_to_ascii_digits_top.sv =====
`timescale 1ns / 1ps

// Renders a 32-bit word as ASCII text, one character per output word,
// most significant digit first; last marks the final character.
// Input channel: in_valid/in_stall with value, use_hex, signed_mode.
// Output channel: out_valid/out_stall with char_code, last.
// A negative value in signed mode is preceded by '-'.
// Decimal: the value runs through the bit-serial double-dabble shifter;
// hex loads its nibbles directly. The emitter then drops leading zeros
// at one digit per cycle and, while the output is not stalled, gives one
// character per cycle; skipped zeros plus digits always make ten, so the
// number of digits does not change the timing. The converter takes the
// next word once it has handed its digits to the emitter, so it can work
// on one word while the emitter still writes out the one before.
// A stalled output holds its character; the emitter and then the
// converter stop, and in_stall stays high until room frees up.
// Reset clears both state machines and the output valid.
module integer_to_ascii_digits_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [ita_pkg::ValueWidth-1:0]      value,
    input  logic                                use_hex,
    input  logic                                signed_mode,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [ita_pkg::CharWidth-1:0]       char_code,
    output logic                                last
);

    logic               word_valid;
    logic               word_take;
    ita_pkg::ita_word_t word;

    ita_conv u_conv
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .value       (value),
        .use_hex     (use_hex),
        .signed_mode (signed_mode),
        .word_valid  (word_valid),
        .word_take   (word_take),
        .word        (word)
    );

    ita_emit u_emit
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_valid (word_valid),
        .word_take  (word_take),
        .word       (word),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .char_code  (char_code),
        .last       (last)
    );

endmodule

// ===== hw/rtl/ita_conv.sv =====
`timescale 1ns / 1ps

// magnitude, then one bit per cycle through a double-dabble shifter (hex skips it)
module ita_conv
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [ita_pkg::ValueWidth-1:0]      value,
    input  logic                                use_hex,
    input  logic                                signed_mode,
    output logic                                word_valid,
    input  logic                                word_take,
    output ita_pkg::ita_word_t                  word
);

    ita_pkg::conv_state_t state_reg, state_next;
    logic [ita_pkg::ValueWidth-1:0]    bin_reg, bin_next;
    logic [ita_pkg::DigitsWidth-1:0]   bcd_reg, bcd_next;
    logic [ita_pkg::BitCountWidth-1:0] cnt_reg, cnt_next;
    logic                              neg_reg, neg_next;

    logic                              accept;
    logic                              neg_in;
    logic [ita_pkg::ValueWidth-1:0]    mag_in;
    logic [ita_pkg::DigitsWidth-1:0]   bcd_adj;

    assign accept = in_valid && !in_stall;
    assign neg_in = signed_mode && value[ita_pkg::ValueWidth-1];
    assign mag_in = neg_in ? (~value + ita_pkg::ValueWidth'(1)) : value;

    always_comb
    begin
        for (int i = 0; i < ita_pkg::NumDigits; i++)
        begin
            if (bcd_reg[i*ita_pkg::DigitWidth +: ita_pkg::DigitWidth] >= 4'd5)
            begin
                bcd_adj[i*ita_pkg::DigitWidth +: ita_pkg::DigitWidth] =
                    bcd_reg[i*ita_pkg::DigitWidth +: ita_pkg::DigitWidth] + 4'd3;
            end
            else
            begin
                bcd_adj[i*ita_pkg::DigitWidth +: ita_pkg::DigitWidth] =
                    bcd_reg[i*ita_pkg::DigitWidth +: ita_pkg::DigitWidth];
            end
        end
    end

    // next state and datapath
    always_comb
    begin
        state_next = state_reg;
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        unique case (state_reg)
            ita_pkg::CONV_IDLE:
            begin
                if (accept)
                begin
                    neg_next = neg_in;
                    cnt_next = '0;
                    if (use_hex)
                    begin
                        bcd_next   = ita_pkg::DigitsWidth'(mag_in);
                        state_next = ita_pkg::CONV_DONE;
                    end
                    else
                    begin
                        bin_next   = mag_in;
                        bcd_next   = '0;
                        state_next = ita_pkg::CONV_SHIFT;
                    end
                end
            end
            ita_pkg::CONV_SHIFT:
            begin
                bcd_next = {bcd_adj[ita_pkg::DigitsWidth-2:0], bin_reg[ita_pkg::ValueWidth-1]};
                bin_next = {bin_reg[ita_pkg::ValueWidth-2:0], 1'b0};
                cnt_next = cnt_reg + ita_pkg::BitCountWidth'(1);
                if (cnt_reg == ita_pkg::BitCountWidth'(ita_pkg::ValueWidth - 1))
                begin
                    state_next = ita_pkg::CONV_DONE;
                end
            end
            ita_pkg::CONV_DONE:
            begin
                if (word_take)
                begin
                    state_next = ita_pkg::CONV_IDLE;
                end
            end
            default:
            begin
                state_next = ita_pkg::CONV_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_stall    = (state_reg != ita_pkg::CONV_IDLE);
        word_valid  = (state_reg == ita_pkg::CONV_DONE);
        word.digits = bcd_reg;
        word.neg    = neg_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ita_pkg::CONV_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
    end

endmodule

// ===== hw/rtl/ita_emit.sv =====
`timescale 1ns / 1ps

// sign, leading-zero skip, then one digit per cycle into the output register while the output is not stalled
module ita_emit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                word_valid,
    output logic                                word_take,
    input  ita_pkg::ita_word_t                  word,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [ita_pkg::CharWidth-1:0]       char_code,
    output logic                                last
);

    ita_pkg::emit_state_t state_reg, state_next;
    logic [ita_pkg::DigitsWidth-1:0] dig_reg, dig_next;
    logic [ita_pkg::LeftWidth-1:0]   left_reg, left_next;
    logic                            out_valid_reg, out_valid_next;
    logic [ita_pkg::CharWidth-1:0]   char_reg, char_next;
    logic                            last_reg, last_next;

    logic                            out_free;
    logic [ita_pkg::DigitWidth-1:0]  top_digit;
    logic                            one_left;

    assign out_free  = !out_valid_reg || !out_stall;
    assign top_digit = dig_reg[ita_pkg::DigitsWidth-1 -: ita_pkg::DigitWidth];
    assign one_left  = (left_reg == ita_pkg::LeftWidth'(1));

    // next state and datapath
    always_comb
    begin
        state_next     = state_reg;
        dig_next       = dig_reg;
        left_next      = left_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            ita_pkg::EMIT_IDLE:
            begin
                if (word_valid)
                begin
                    dig_next   = word.digits;
                    left_next  = ita_pkg::LeftWidth'(ita_pkg::NumDigits);
                    state_next = word.neg ? ita_pkg::EMIT_SIGN : ita_pkg::EMIT_SKIP;
                end
            end
            ita_pkg::EMIT_SIGN:
            begin
                if (out_free)
                begin
                    char_next      = ita_pkg::CharMinus;
                    last_next      = 1'b0;
                    out_valid_next = 1'b1;
                    state_next     = ita_pkg::EMIT_SKIP;
                end
            end
            ita_pkg::EMIT_SKIP:
            begin
                if ((top_digit == '0) && !one_left)
                begin
                    dig_next  = {dig_reg[ita_pkg::DigitsWidth-ita_pkg::DigitWidth-1:0],
                                 {ita_pkg::DigitWidth{1'b0}}};
                    left_next = left_reg - ita_pkg::LeftWidth'(1);
                end
                else
                begin
                    state_next = ita_pkg::EMIT_DIGIT;
                end
            end
            ita_pkg::EMIT_DIGIT:
            begin
                if (out_free)
                begin
                    char_next      = ita_pkg::digit_char(top_digit);
                    last_next      = one_left;
                    out_valid_next = 1'b1;
                    dig_next  = {dig_reg[ita_pkg::DigitsWidth-ita_pkg::DigitWidth-1:0],
                                 {ita_pkg::DigitWidth{1'b0}}};
                    left_next = left_reg - ita_pkg::LeftWidth'(1);
                    if (one_left)
                    begin
                        state_next = ita_pkg::EMIT_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ita_pkg::EMIT_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        word_take = (state_reg == ita_pkg::EMIT_IDLE) && word_valid;
        out_valid = out_valid_reg;
        char_code = char_reg;
        last      = last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ita_pkg::EMIT_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg  <= dig_next;
        left_reg <= left_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

endmodule

// ===== bench/tb_integer_to_ascii_digits_top.sv =====
`timescale 1ns / 1ps

module tb_integer_to_ascii_digits_top;

    localparam int unsigned StallLimit = 4000;
    localparam int unsigned HoldCycles = 500;
    localparam int unsigned TailCycles = 64;
    localparam int unsigned MaxDigits  = 10;

    typedef struct packed {
        logic [ita_pkg::CharWidth-1:0] code;
        logic                          last;
    } char_word_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_stall;
    logic [ita_pkg::ValueWidth-1:0]  value = '0;
    logic                            use_hex = 1'b0;
    logic                            signed_mode = 1'b0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic [ita_pkg::CharWidth-1:0]   char_code;
    logic                            last;

    char_word_t  expected_chars[$];
    int unsigned fail_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_left = 0;
    int unsigned quiet_cycles = 0;

    integer_to_ascii_digits_top dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .value       (value),
        .use_hex     (use_hex),
        .signed_mode (signed_mode),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .char_code   (char_code),
        .last        (last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // expected text of one word, sign first, most significant digit first
    function automatic void predict_text(input logic [ita_pkg::ValueWidth-1:0] v,
                                         input logic hex, input logic sgn);
        logic [ita_pkg::ValueWidth-1:0] mag;
        logic [ita_pkg::ValueWidth-1:0] base;
        logic [ita_pkg::ValueWidth-1:0] rem;
        logic [ita_pkg::CharWidth-1:0]  digs[MaxDigits];
        char_word_t                     w;
        int                             nd;
        mag  = v;
        base = hex ? 32'd16 : 32'd10;
        nd   = 0;
        if (sgn && mag[ita_pkg::ValueWidth-1])
        begin
            w.code = ita_pkg::CharMinus;
            w.last = 1'b0;
            expected_chars.push_back(w);
            mag = 32'd0 - mag;
        end
        do
        begin
            rem = mag % base;
            digs[nd] = (rem < 10) ? ita_pkg::CharZero + ita_pkg::CharWidth'(rem)
                                  : ita_pkg::CharA + ita_pkg::CharWidth'(rem - 10);
            nd++;
            mag = mag / base;
        end
        while (mag != 0 && nd < MaxDigits);
        for (int i = nd - 1; i >= 0; i--)
        begin
            w.code = digs[i];
            w.last = (i == 0);
            expected_chars.push_back(w);
        end
    endfunction

    task automatic send_word(input logic [ita_pkg::ValueWidth-1:0] v, input logic hex,
                             input logic sgn);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        value       <= v;
        use_hex     <= hex;
        signed_mode <= sgn;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        predict_text(v, hex, sgn);
    endtask

    task automatic stop_sending();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_chars.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic [ita_pkg::ValueWidth-1:0] random_value();
        logic [ita_pkg::ValueWidth-1:0] v;
        logic [ita_pkg::ValueWidth-1:0] p;
        p = 1;
        case ($urandom_range(4))
            0: v = $urandom;
            1: v = $urandom_range(0, 300);
            2: v = 32'd0 - $urandom_range(1, 300);
            3: v = (32'd1 << $urandom_range(31)) - $urandom_range(0, 1);
            default:
            begin
                repeat ($urandom_range(9)) p = p * 10;
                v = p + $urandom_range(0, 2) - 1;
            end
        endcase
        return v;
    endfunction

    task automatic test_directed_cases();
        send_word(32'd0, 1'b0, 1'b0);
        send_word(32'd0, 1'b1, 1'b0);
        send_word(32'd0, 1'b0, 1'b1);
        send_word(32'd0, 1'b1, 1'b1);
        send_word(32'hffff_ffff, 1'b0, 1'b0);
        send_word(32'hffff_ffff, 1'b1, 1'b0);
        send_word(32'hffff_ffff, 1'b0, 1'b1);
        send_word(32'hffff_ffff, 1'b1, 1'b1);
        send_word(32'h8000_0000, 1'b0, 1'b1);
        send_word(32'h8000_0000, 1'b1, 1'b1);
        send_word(32'h8000_0000, 1'b0, 1'b0);
        send_word(32'h8000_0000, 1'b1, 1'b0);
        send_word(32'h7fff_ffff, 1'b0, 1'b1);
        send_word(32'h7fff_ffff, 1'b1, 1'b1);
        send_word(32'd9, 1'b0, 1'b0);
        send_word(32'd10, 1'b0, 1'b1);
        send_word(32'd15, 1'b1, 1'b0);
        send_word(32'd16, 1'b1, 1'b1);
        send_word(32'd999_999_999, 1'b0, 1'b0);
        send_word(32'd1_000_000_000, 1'b0, 1'b1);
        send_word(32'habcd_ef12, 1'b1, 1'b0);
        send_word(32'h0123_4567, 1'b1, 1'b1);
        send_word(32'hfedc_ba98, 1'b0, 1'b1);
    endtask

    task automatic test_random_words(input int unsigned count);
        repeat (count)
        begin
            send_word(random_value(), 1'($urandom_range(1)), 1'($urandom_range(1)));
        end
    endtask

    // receiver holds off while words keep coming, so the block backs up
    task automatic test_output_hold();
        hold_left = HoldCycles;
        repeat (24)
        begin
            send_word(random_value(), 1'($urandom_range(1)), 1'($urandom_range(1)));
        end
    endtask

    task automatic test_pause_until_drained();
        test_random_words(6);
        stop_sending();
        wait_drained();
        test_random_words(6);
    endtask

    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        char_word_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_chars.size() == 0)
            begin
                $error("unexpected word: char_code %h last %b", char_code, last);
                fail_count++;
            end
            else
            begin
                w = expected_chars.pop_front();
                if (char_code !== w.code)
                begin
                    $error("char_code: expected %h, got %h", w.code, char_code);
                    fail_count++;
                end
                if (last !== w.last)
                begin
                    $error("last: expected %b, got %b", w.last, last);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (rst_n && out_valid && !out_stall))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= StallLimit)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 16;
        recv_idle_pct = 69;
        test_directed_cases();
        test_random_words(140);
        test_output_hold();

        send_idle_pct = 69;
        recv_idle_pct = 16;
        test_random_words(140);
        test_pause_until_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_words(91);

        stop_sending();
        wait_drained();
        repeat (TailCycles) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
